// ===== hw/rtl/uue_pkg.sv =====
// Shared types, constants and the 6-bit character mapping for the uuencode line encoder.
// Used by uuencode_line_encoder and its checker; depends on nothing else.
`default_nettype none

package uue_pkg;

  localparam logic [6:0] NL_CHAR   = 7'd10;
  localparam logic [6:0] CHAR_BIAS = 7'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_FETCH,
    ST_EMIT,
    ST_NL
  } uue_state_e;

  // Map a 6-bit value onto the printable range starting at space.
  function automatic logic [6:0] uue_enc6(input logic [5:0] v);
    uue_enc6 = {1'b0, v} + CHAR_BIAS;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/uuencode_line_encoder.sv =====
// uuencode line encoder: collects input bytes in a line store and emits one encoded line.
// Depends on uue_pkg; the line store is a memory inside this module.
// Throughput: one input word per cycle while collecting; a flushed line is sent as a length
// character, then per group of three bytes a fetch of the three bytes and 4 output words,
// then a newline, plus any output stall, before the next input word is taken.
// Reset: asynchronous, active low; clears the sequencer, fill count and output valid.
`default_nettype none

module uuencode_line_encoder #(
  parameter int LINE_BYTES = 45
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       final_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [6:0]      out_char_o,
  output logic            run_last_o
);
  import uue_pkg::*;

  localparam int AddrW = $clog2(LINE_BYTES);
  localparam int CntW  = $clog2(LINE_BYTES + 1);
  localparam int PtrW  = CntW + 1;

  uue_state_e        state_q, state_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic [CntW-1:0]   len_q, len_d;
  logic [PtrW-1:0]   ptr_q, ptr_d;
  logic [1:0]        step_q, step_d;
  logic [23:0]       grp_q, grp_d;
  logic              out_valid_q, out_valid_d;
  logic [6:0]        out_char_q, out_char_d;
  logic              run_last_q, run_last_d;

  logic [7:0]        store_mem [LINE_BYTES];
  logic [7:0]        rd_data_q;
  logic              rd_vld_q;

  logic              in_fire;
  logic              out_free;
  logic [PtrW-1:0]   rd_idx;
  logic              rd_en;
  logic [CntW-1:0]   fill_inc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign run_last_o  = run_last_q;

  assign fill_inc = fill_q + CntW'(1);
  assign rd_idx   = ptr_q + PtrW'(step_q);
  // Bytes past the line length are never read; they enter the group as zero.
  assign rd_en    = (state_q == ST_FETCH) && (step_q != 2'd3) && (rd_idx < PtrW'(len_q));

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      store_mem[fill_q[AddrW-1:0]] <= data_byte_i;
    end
    if (rd_en) begin
      rd_data_q <= store_mem[rd_idx[AddrW-1:0]];
    end
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    len_d       = len_q;
    ptr_d       = ptr_q;
    step_d      = step_q;
    grp_d       = grp_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    run_last_d  = run_last_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if ((fill_inc == CntW'(LINE_BYTES)) || final_byte_i) begin
            len_d   = fill_inc;
            fill_d  = '0;
            state_d = ST_LEN;
          end else begin
            fill_d = fill_inc;
          end
        end
      end
      ST_LEN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = uue_enc6(6'(len_q));
          run_last_d  = 1'b0;
          ptr_d       = '0;
          step_d      = 2'd0;
          state_d     = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // Read data is registered and lands in the step after its address, so steps 1..3 shift it in.
        if (step_q != 2'd0) begin
          grp_d = {grp_q[15:0], (rd_vld_q ? rd_data_q : 8'h00)};
        end
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          ptr_d   = ptr_q + PtrW'(3);
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = uue_enc6(grp_q[23:18]);
          run_last_d  = 1'b0;
          grp_d       = {grp_q[17:0], 6'h00};
          step_d      = step_q + 2'd1;
          if (step_q == 2'd3) begin
            state_d = (ptr_q >= PtrW'(len_q)) ? ST_NL : ST_FETCH;
          end
        end
      end
      ST_NL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = NL_CHAR;
          run_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      step_q      <= 2'd0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      rd_vld_q    <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    ptr_q      <= ptr_d;
    grp_q      <= grp_d;
    out_char_q <= out_char_d;
    run_last_q <= run_last_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/uue_checker.sv =====
// Port-level checks for the uuencode line encoder, attached by the bind below.
// Depends on uue_pkg for the newline code.
`default_nettype none

module uue_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       final_byte_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [6:0] out_char_o,
  input wire logic       run_last_o
);
  import uue_pkg::*;

  // A stalled output word keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o) && $stable(run_last_o))
    else $error("output word changed while stalled");

  // The line-end flag sits on the newline and nowhere else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (run_last_o == (out_char_o == NL_CHAR)))
    else $error("line-end flag does not match newline");

  // A final byte always flushes a line, so intake stops right after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && final_byte_i |=> !in_ready_o)
    else $error("final byte did not start a line");

  // Printable characters stay within the encoded range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> (out_char_o >= 7'd32) && (out_char_o <= 7'd95))
    else $error("character out of range");

endmodule

bind uuencode_line_encoder uue_checker u_uue_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .final_byte_i (final_byte_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_char_o   (out_char_o),
  .run_last_o   (run_last_o)
);

`default_nettype wire
